FILE: rtl/lfsc_pkg.sv
`timescale 1ns / 1ps
package lfsc_pkg;

	localparam int PosW   = 16;
	localparam int SpeedW = 16;
	localparam int GainW  = 16;
	localparam int MaxW   = 15;
	localparam int CountW = 7;
	localparam int IntegW = 26;
	localparam int PhaseW = 3;
	localparam int AddrW  = 5;
	localparam int DataW  = 32;

	// |pos| >= 0.95 is an edge, |pos| <= 0.3 is centered (Q1.14)
	localparam logic signed [PosW-1:0]   EdgeQ   = 16'sd15565;
	localparam logic signed [PosW-1:0]   CentreQ = 16'sd4915;
	localparam logic signed [IntegW-1:0] IntegSat = 26'sd16777216;
	localparam logic [CountW-1:0]        CountMax = 7'd127;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_MAX_SPEED   = 3'd3,
		REG_MIN_SPEED   = 3'd4,
		REG_WEAVE_THR   = 3'd5,
		REG_SLOW_SPEED  = 3'd6,
		REG_COUNT_LIMIT = 3'd7
	} cfg_reg_t;

endpackage

FILE: rtl/lfsc_in_if.sv
`timescale 1ns / 1ps
interface lfsc_in_if;
	import lfsc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [PosW-1:0] line_pos;

	modport source (output valid, output line_pos, input ready);
	modport sink   (input valid, input line_pos, output ready);

endinterface

FILE: rtl/lfsc_out_if.sv
`timescale 1ns / 1ps
interface lfsc_out_if;
	import lfsc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [SpeedW-1:0] left_speed;
	logic signed [SpeedW-1:0] right_speed;
	logic                     sync_pulse;
	logic [PhaseW-1:0]        phase_now;

	modport source (output valid, output left_speed, output right_speed,
		output sync_pulse, output phase_now, input ready);
	modport sink   (input valid, input left_speed, input right_speed,
		input sync_pulse, input phase_now, output ready);

endinterface

FILE: rtl/line_follow_sequence_controller_core.sv
`timescale 1ns / 1ps
// Line follower sequence controller with PID steering and differential drive.
// in_ch carries one signed Q1.14 line position per transaction; out_ch returns
// one transaction per input: left/right wheel speeds, the weave marker level
// and the phase that produced the result. Gains, speeds, weave threshold and
// the counted-phase length are written over the APB port (register i at
// byte address 4*i); the user must write them only while the block is idle,
// as the block itself does not enforce this. An input transaction lands in
// the input register, then the PID multiplies, clamps and phase update land
// in the result register. One item per cycle is sustained while out_ch is
// ready; the limit is the update of the PID state (integral, last position,
// phase) that every item depends on.
// A stalled receiver holds the result register; the input register still
// takes one more item, after which in_ch.ready drops until out_ch drains.
// Reset (arst_n low) empties both registers, loads the default register
// values and returns to the first follow phase with cleared PID state.
// After the last follow phase meets an edge the block stays stopped,
// returning zero speeds, until the next reset.
module line_follow_sequence_controller_core (
	input  logic                        clk,
	input  logic                        arst_n,
	lfsc_in_if.sink                     in_ch,
	lfsc_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfsc_pkg::AddrW-1:0]  paddr,
	input  logic [lfsc_pkg::DataW-1:0]  pwdata,
	output logic [lfsc_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import lfsc_pkg::*;

	typedef enum logic [PhaseW-1:0] {
		PH_FOLLOW_A     = 3'd0,
		PH_SPIN_CCW     = 3'd1,
		PH_FOLLOW_COUNT = 3'd2,
		PH_WEAVE        = 3'd3,
		PH_SPIN_CW      = 3'd4,
		PH_FOLLOW_B     = 3'd5,
		PH_STOP         = 3'd6
	} phase_t;

	// configuration registers
	logic [GainW-1:0]         prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [MaxW-1:0]          max_speed_q, weave_thr_q;
	logic signed [SpeedW-1:0] min_speed_q, slow_speed_q;
	logic [CountW-1:0]        count_limit_q;

	// controller state
	phase_t                   phase_q, phase_d;
	logic signed [PosW-1:0]   last_pos_q, last_pos_d;
	logic signed [IntegW-1:0] integ_q, integ_d;
	logic [CountW-1:0]        count_q, count_d;
	logic                     flag_q, flag_d;
	logic                     pulse_q, pulse_d;

	// pipeline
	logic                     v_s1, v_s2, adv;
	logic signed [PosW-1:0]   pos_s1;
	logic signed [SpeedW-1:0] left_s2, right_s2;
	logic                     pulse_s2;
	logic [PhaseW-1:0]        phase_s2;

	logic                     cfg_wr;
	cfg_reg_t                 cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[AddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 16'd256;
			integ_gain_q  <= 16'd0;
			deriv_gain_q  <= 16'd5120;
			max_speed_q   <= 15'd6554;
			min_speed_q   <= 16'sd0;
			weave_thr_q   <= 15'd5734;
			slow_speed_q  <= 16'sd3277;
			count_limit_q <= 7'd100;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:   prop_gain_q   <= pwdata[GainW-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= pwdata[GainW-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= pwdata[GainW-1:0];
				REG_MAX_SPEED:   max_speed_q   <= pwdata[MaxW-1:0];
				REG_MIN_SPEED:   min_speed_q   <= $signed(pwdata[SpeedW-1:0]);
				REG_WEAVE_THR:   weave_thr_q   <= pwdata[MaxW-1:0];
				REG_SLOW_SPEED:  slow_speed_q  <= $signed(pwdata[SpeedW-1:0]);
				REG_COUNT_LIMIT: count_limit_q <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_PROP_GAIN:   prdata = {16'd0, prop_gain_q};
			REG_INTEG_GAIN:  prdata = {16'd0, integ_gain_q};
			REG_DERIV_GAIN:  prdata = {16'd0, deriv_gain_q};
			REG_MAX_SPEED:   prdata = {17'd0, max_speed_q};
			REG_MIN_SPEED:   prdata = {{16{min_speed_q[SpeedW-1]}}, min_speed_q};
			REG_WEAVE_THR:   prdata = {17'd0, weave_thr_q};
			REG_SLOW_SPEED:  prdata = {{16{slow_speed_q[SpeedW-1]}}, slow_speed_q};
			REG_COUNT_LIMIT: prdata = {25'd0, count_limit_q};
			default:         prdata = '0;
		endcase
	end

	// handshake
	assign adv          = v_s1 & (~v_s2 | out_ch.ready);
	assign in_ch.ready  = ~v_s1 | adv;
	assign out_ch.valid = v_s2;
	assign out_ch.left_speed  = left_s2;
	assign out_ch.right_speed = right_s2;
	assign out_ch.sync_pulse  = pulse_s2;
	assign out_ch.phase_now   = phase_s2;

	// PID datapath
	logic signed [PosW:0]     diff;
	logic signed [IntegW:0]   integ_sum;
	logic signed [IntegW-1:0] integ_sat;
	logic signed [32:0]       prod_p;
	logic signed [42:0]       prod_i;
	logic signed [33:0]       prod_d;
	logic signed [43:0]       acc;
	logic signed [35:0]       power;
	logic signed [36:0]       max_ext, right_raw, left_raw;
	logic signed [SpeedW-1:0] pid_left, pid_right;
	logic signed [SpeedW-1:0] max_s, neg_max_s;

	assign diff      = {pos_s1[PosW-1], pos_s1} - {last_pos_q[PosW-1], last_pos_q};
	assign integ_sum = {integ_q[IntegW-1], integ_q}
		+ {{(IntegW+1-PosW){pos_s1[PosW-1]}}, pos_s1};

	always_comb begin
		if (integ_sum > $signed({IntegSat[IntegW-1], IntegSat}))
			integ_sat = IntegSat;
		else if (integ_sum < -$signed({IntegSat[IntegW-1], IntegSat}))
			integ_sat = -IntegSat;
		else
			integ_sat = integ_sum[IntegW-1:0];
	end

	assign prod_p = $signed({1'b0, prop_gain_q}) * pos_s1;
	assign prod_i = $signed({1'b0, integ_gain_q}) * integ_sat;
	assign prod_d = $signed({1'b0, deriv_gain_q}) * diff;
	assign acc    = {{11{prod_p[32]}}, prod_p} + {prod_i[42], prod_i}
		+ {{10{prod_d[33]}}, prod_d};
	// arithmetic shift gives floor division by 256
	assign power     = acc[43:8];
	assign max_ext   = $signed({22'd0, max_speed_q});
	assign right_raw = max_ext + {power[35], power};
	assign left_raw  = max_ext - {power[35], power};
	assign max_s     = $signed({1'b0, max_speed_q});
	assign neg_max_s = -max_s;

	function automatic logic signed [SpeedW-1:0] clamp_speed(
		input logic signed [36:0]        v,
		input logic signed [SpeedW-1:0]  lo,
		input logic [MaxW-1:0]           hi
	);
		logic signed [36:0] lo_ext;
		logic signed [36:0] hi_ext;
		lo_ext = {{21{lo[SpeedW-1]}}, lo};
		hi_ext = $signed({22'd0, hi});
		if (v < lo_ext)
			clamp_speed = lo;
		else if (v > hi_ext)
			clamp_speed = $signed({1'b0, hi});
		else
			clamp_speed = v[SpeedW-1:0];
	endfunction

	assign pid_right = clamp_speed(right_raw, min_speed_q, max_speed_q);
	assign pid_left  = clamp_speed(left_raw, min_speed_q, max_speed_q);

	// edge, center and weave tests
	logic                   at_edge, centred, below_thr, above_thr, count_done;
	logic signed [PosW:0]   pos_ext, thr_ext;
	logic [CountW-1:0]      count_inc;

	assign at_edge   = (pos_s1 >= EdgeQ) | (pos_s1 <= -EdgeQ);
	assign centred   = (pos_s1 >= -CentreQ) & (pos_s1 <= CentreQ);
	assign pos_ext   = {pos_s1[PosW-1], pos_s1};
	assign thr_ext   = $signed({2'b00, weave_thr_q});
	assign below_thr = pos_ext < -thr_ext;
	assign above_thr = pos_ext > thr_ext;
	assign count_inc = (count_q < CountMax) ? count_q + 7'd1 : count_q;
	// a zero limit ends the phase after one sample, like a limit of one
	assign count_done = count_inc >= count_limit_q;

	logic signed [SpeedW-1:0] left_d, right_d;

	always_comb begin
		phase_d    = phase_q;
		last_pos_d = last_pos_q;
		integ_d    = integ_q;
		count_d    = count_q;
		flag_d     = flag_q;
		pulse_d    = pulse_q;
		left_d     = '0;
		right_d    = '0;
		unique case (phase_q) inside
			PH_FOLLOW_A, PH_FOLLOW_B: begin
				left_d     = pid_left;
				right_d    = pid_right;
				last_pos_d = pos_s1;
				integ_d    = integ_sat;
				if (at_edge)
					phase_d = (phase_q == PH_FOLLOW_A) ? PH_SPIN_CCW : PH_STOP;
			end
			PH_SPIN_CCW: begin
				left_d  = neg_max_s;
				right_d = max_s;
				if (centred) begin
					phase_d    = PH_FOLLOW_COUNT;
					last_pos_d = '0;
					integ_d    = '0;
					count_d    = '0;
				end
			end
			PH_FOLLOW_COUNT: begin
				left_d     = pid_left;
				right_d    = pid_right;
				last_pos_d = pos_s1;
				integ_d    = integ_sat;
				count_d    = count_inc;
				if (count_done) begin
					phase_d = PH_WEAVE;
					flag_d  = 1'b1;
				end
			end
			PH_WEAVE: begin
				// output follows the flag from before this sample
				if (flag_q) begin
					left_d  = max_s;
					right_d = slow_speed_q;
					pulse_d = 1'b1;
				end else begin
					left_d  = slow_speed_q;
					right_d = max_s;
					pulse_d = 1'b0;
				end
				if (below_thr)
					flag_d = 1'b1;
				if (above_thr)
					flag_d = 1'b0;
				if (at_edge) begin
					pulse_d = 1'b0;
					phase_d = PH_SPIN_CW;
				end
			end
			PH_SPIN_CW: begin
				left_d  = max_s;
				right_d = neg_max_s;
				if (centred) begin
					phase_d    = PH_FOLLOW_B;
					last_pos_d = '0;
					integ_d    = '0;
				end
			end
			default: begin
				left_d  = '0;
				right_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			phase_q    <= PH_FOLLOW_A;
			last_pos_q <= '0;
			integ_q    <= '0;
			count_q    <= '0;
			flag_q     <= 1'b1;
			pulse_q    <= 1'b0;
		end else begin
			if (in_ch.valid & in_ch.ready)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				v_s2 <= 1'b1;
			else if (out_ch.ready)
				v_s2 <= 1'b0;
			if (adv) begin
				phase_q    <= phase_d;
				last_pos_q <= last_pos_d;
				integ_q    <= integ_d;
				count_q    <= count_d;
				flag_q     <= flag_d;
				pulse_q    <= pulse_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid & in_ch.ready)
			pos_s1 <= in_ch.line_pos;
		if (adv) begin
			left_s2  <= left_d;
			right_s2 <= right_d;
			pulse_s2 <= pulse_d;
			phase_s2 <= phase_q;
		end
	end

endmodule

FILE: rtl/lfsc_checker.sv
`timescale 1ns / 1ps
module lfsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [lfsc_pkg::SpeedW-1:0] left_speed,
	input logic signed [lfsc_pkg::SpeedW-1:0] right_speed,
	input logic                              sync_pulse,
	input logic [lfsc_pkg::PhaseW-1:0]       phase_now
);
	import lfsc_pkg::*;

	// a stalled result transaction must hold its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed)
			&& $stable(right_speed) && $stable(sync_pulse) && $stable(phase_now))
		else $error("result changed while stalled");

	// with the result register empty the input side must take a transaction
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_pulse_weave: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sync_pulse |-> phase_now == 3'd3)
		else $error("marker high outside weave");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_now == 3'd6 |-> left_speed == '0 && right_speed == '0)
		else $error("nonzero speed while stopped");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase_now != 3'd7)
		else $error("unused phase reported");

endmodule

bind line_follow_sequence_controller_core lfsc_checker u_lfsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.left_speed  (out_ch.left_speed),
	.right_speed (out_ch.right_speed),
	.sync_pulse  (out_ch.sync_pulse),
	.phase_now   (out_ch.phase_now)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import lfsc_pkg::*;

	localparam int CycleLimit = 400000;

	typedef enum logic [PhaseW-1:0] {
		PH_FOLLOW      = 3'd0,
		PH_SPIN_CCW    = 3'd1,
		PH_COUNTED     = 3'd2,
		PH_WEAVE       = 3'd3,
		PH_SPIN_CW     = 3'd4,
		PH_FOLLOW_LAST = 3'd5,
		PH_STOPPED     = 3'd6
	} phase_t;

	typedef struct packed {
		logic signed [SpeedW-1:0] left;
		logic signed [SpeedW-1:0] right;
		logic                     pulse;
		logic [PhaseW-1:0]        ph;
	} wheel_cmd_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AddrW-1:0]    paddr;
	logic [DataW-1:0]    pwdata;
	logic [DataW-1:0]    prdata;
	logic                pready;

	lfsc_in_if  in_ch ();
	lfsc_out_if out_ch ();

	line_follow_sequence_controller_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// controller copy: registers
	longint kp = 256, ki = 0, kd = 5120;
	longint spd_max = 6554, spd_min = 0, thr = 5734, slow = 3277;
	longint cnt_lim = 100;
	// controller copy: state
	phase_t ph = PH_FOLLOW;
	longint last_pos = 0;
	longint integ = 0;
	longint cnt = 0;
	bit     wflag = 1'b1;
	bit     pin = 1'b0;

	logic signed [PosW-1:0] pending[$];
	wheel_cmd_t             wheel_q[$];

	bit  idling = 1'b1;
	bit  in_taken = 1'b0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  mismatches = 0;
	int  samples_in = 0;
	int  results_out = 0;
	int  reg_writes = 0;
	int  cycle_count = 0;
	int  seen_phase[0:7];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit at_edge(input longint p);
		return p >= longint'(EdgeQ) || p <= -longint'(EdgeQ);
	endfunction

	function automatic bit centred(input longint p);
		return p >= -longint'(CentreQ) && p <= longint'(CentreQ);
	endfunction

	// lower bound is tested first: when the bounds cross, values below it get it, all others the upper bound
	function automatic longint clamp_speed(input longint v);
		if (v < spd_min)
			return spd_min;
		if (v > spd_max)
			return spd_max;
		return v;
	endfunction

	task automatic pid_drive(input longint p, output longint lw, output longint rw);
		longint acc;
		longint pw;
		integ += p;
		if (integ > longint'(IntegSat))
			integ = longint'(IntegSat);
		if (integ < -longint'(IntegSat))
			integ = -longint'(IntegSat);
		acc = kp * p + ki * integ + kd * (p - last_pos);
		last_pos = p;
		pw = acc >>> 8;
		rw = clamp_speed(spd_max + pw);
		lw = clamp_speed(spd_max - pw);
	endtask

	task automatic steer_predict(input logic signed [PosW-1:0] pos, output wheel_cmd_t c);
		longint p;
		longint lw;
		longint rw;
		p = pos;
		lw = 0;
		rw = 0;
		c.ph = ph;
		case (ph) inside
			PH_FOLLOW, PH_FOLLOW_LAST: begin
				pid_drive(p, lw, rw);
				if (at_edge(p))
					ph = (ph == PH_FOLLOW) ? PH_SPIN_CCW : PH_STOPPED;
			end
			PH_SPIN_CCW: begin
				lw = -spd_max;
				rw = spd_max;
				if (centred(p)) begin
					ph = PH_COUNTED;
					last_pos = 0;
					integ = 0;
					cnt = 0;
				end
			end
			PH_COUNTED: begin
				pid_drive(p, lw, rw);
				if (cnt < longint'(CountMax))
					cnt++;
				if (cnt >= cnt_lim) begin
					ph = PH_WEAVE;
					wflag = 1'b1;
				end
			end
			PH_WEAVE: begin
				// output follows the flag as it was before this sample
				if (wflag) begin
					lw = spd_max;
					rw = slow;
					pin = 1'b1;
				end else begin
					lw = slow;
					rw = spd_max;
					pin = 1'b0;
				end
				if (p < -thr)
					wflag = 1'b1;
				if (p > thr)
					wflag = 1'b0;
				if (at_edge(p)) begin
					pin = 1'b0;
					ph = PH_SPIN_CW;
				end
			end
			PH_SPIN_CW: begin
				lw = spd_max;
				rw = -spd_max;
				if (centred(p)) begin
					ph = PH_FOLLOW_LAST;
					last_pos = 0;
					integ = 0;
				end
			end
			default: ;
		endcase
		c.left = lw[SpeedW-1:0];
		c.right = rw[SpeedW-1:0];
		c.pulse = pin;
	endtask

	function automatic void check_field(input string what, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic int any_pos();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic int off_edge();
		return int'($urandom_range(0, 31128)) - 15564;
	endfunction

	function automatic int off_centre();
		int m;
		m = int'($urandom_range(4916, 16384));
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	task automatic feed(input int pos);
		pending.push_back(pos[PosW-1:0]);
	endtask

	task automatic settle();
		while (pending.size() != 0 || wheel_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input cfg_reg_t r, input int val);
		logic [DataW-1:0] got;
		logic [DataW-1:0] mask;
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= DataW'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
		case (r)
			REG_PROP_GAIN:   kp = val & 16'hFFFF;
			REG_INTEG_GAIN:  ki = val & 16'hFFFF;
			REG_DERIV_GAIN:  kd = val & 16'hFFFF;
			REG_MAX_SPEED:   spd_max = val & 15'h7FFF;
			REG_MIN_SPEED:   spd_min = longint'($signed(val[15:0]));
			REG_WEAVE_THR:   thr = val & 15'h7FFF;
			REG_SLOW_SPEED:  slow = longint'($signed(val[15:0]));
			REG_COUNT_LIMIT: cnt_lim = val & 7'h7F;
			default: ;
		endcase
		case (r) inside
			REG_MAX_SPEED, REG_WEAVE_THR: mask = 32'h7FFF;
			REG_COUNT_LIMIT:              mask = 32'h7F;
			default:                      mask = 32'hFFFF;
		endcase
		if (((got ^ DataW'(val)) & mask) != 0) begin
			mismatches++;
			$display("%0t: %s read back: expected %0h, got %0h", $time, r.name(),
				DataW'(val) & mask, got & mask);
		end
	endtask

	// sender and receiver; everything changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (src_gap > 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					if (idling && $urandom_range(0, 19) == 0) begin
						src_gap = $urandom_range(0, 8);
						in_ch.valid <= 1'b0;
					end else begin
						in_ch.valid <= 1'b1;
						in_ch.line_pos <= pending[0];
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			in_taken = 1'b0;
			if (snk_gap > 0) begin
				snk_gap--;
				out_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 15) == 0) begin
				snk_gap = $urandom_range(0, 8);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// transaction monitor: predict on input, check on output
	always @(posedge clk) begin
		wheel_cmd_t w;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				void'(pending.pop_front());
				in_taken = 1'b1;
				samples_in++;
				steer_predict(in_ch.line_pos, w);
				wheel_q.push_back(w);
			end
			if (out_ch.valid && out_ch.ready) begin
				results_out++;
				if (wheel_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, got %0d/%0d/%0b/%0d", $time,
						out_ch.left_speed, out_ch.right_speed, out_ch.sync_pulse,
						out_ch.phase_now);
				end else begin
					w = wheel_q.pop_front();
					seen_phase[w.ph]++;
					check_field("left_speed", w.left, out_ch.left_speed);
					check_field("right_speed", w.right, out_ch.right_speed);
					check_field("sync_pulse", {31'd0, w.pulse}, {31'd0, out_ch.sync_pulse});
					check_field("phase_now", {29'd0, w.ph}, {29'd0, out_ch.phase_now});
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.line_pos = '0;
		out_ch.ready = 1'b0;
		foreach (seen_phase[i])
			seen_phase[i] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first follow phase on reset settings, edge and centre boundaries
		feed(0); feed(1); feed(-1); feed(15564); feed(-15564);
		feed(4915); feed(-4916); feed(8192); feed(-8192);

		reg_write(REG_PROP_GAIN, 65535);
		reg_write(REG_DERIV_GAIN, 0);
		reg_write(REG_MAX_SPEED, 16384);
		reg_write(REG_MIN_SPEED, -16384);
		repeat (60) feed(off_edge());

		reg_write(REG_PROP_GAIN, 0);
		reg_write(REG_DERIV_GAIN, 65535);
		reg_write(REG_MAX_SPEED, 0);
		reg_write(REG_MIN_SPEED, 0);
		repeat (40) feed(off_edge());

		// min above max: values below min give min, the rest give max
		reg_write(REG_PROP_GAIN, 300);
		reg_write(REG_DERIV_GAIN, 1000);
		reg_write(REG_MAX_SPEED, 200);
		reg_write(REG_MIN_SPEED, 16384);
		repeat (30) feed(off_edge());

		// wind the integral up
		reg_write(REG_PROP_GAIN, 256);
		reg_write(REG_INTEG_GAIN, 1);
		reg_write(REG_DERIV_GAIN, 5120);
		reg_write(REG_MAX_SPEED, 16384);
		reg_write(REG_MIN_SPEED, -16384);
		repeat (6) begin
			repeat (50)
				feed($urandom_range(0, 9) == 0 ? off_edge() : int'($urandom_range(14500, 15564)));
			while (pending.size() != 0)
				@(negedge clk);
		end
		repeat (10) feed(15564);
		// large kp pulls against the wound-up integral
		reg_write(REG_PROP_GAIN, 65535);
		reg_write(REG_DERIV_GAIN, 0);
		repeat (30) feed(-int'($urandom_range(100, 400)));
		feed(16384);

		// counter-clockwise spin
		feed(4916); feed(-4916);
		reg_write(REG_MAX_SPEED, 0);
		feed(16384); feed(-16384);
		reg_write(REG_MAX_SPEED, 16384);
		repeat (20) feed(off_centre());
		reg_write(REG_COUNT_LIMIT, 127);
		reg_write(REG_PROP_GAIN, 512);
		reg_write(REG_INTEG_GAIN, 64);
		reg_write(REG_DERIV_GAIN, 2048);
		reg_write(REG_MAX_SPEED, 9000);
		reg_write(REG_MIN_SPEED, -3000);
		feed(-4915);

		// counted follow, cut short by a zero limit
		feed(-16384); feed(16384);
		repeat (38) feed(any_pos());
		reg_write(REG_COUNT_LIMIT, 0);
		feed(any_pos());

		// weave
		reg_write(REG_WEAVE_THR, 5734);
		reg_write(REG_SLOW_SPEED, -16384);
		reg_write(REG_MAX_SPEED, 16384);
		feed(5734); feed(5735); feed(-5734); feed(-5735); feed(0);
		reg_write(REG_WEAVE_THR, 0);
		reg_write(REG_SLOW_SPEED, 16384);
		reg_write(REG_MAX_SPEED, 0);
		repeat (30) feed(off_edge());
		reg_write(REG_WEAVE_THR, 16384);
		reg_write(REG_SLOW_SPEED, 3277);
		reg_write(REG_MAX_SPEED, 6554);
		repeat (30) feed(off_edge());
		repeat (3) begin
			reg_write(REG_WEAVE_THR, $urandom_range(0, 16384));
			reg_write(REG_SLOW_SPEED, int'($urandom_range(0, 32768)) - 16384);
			reg_write(REG_MAX_SPEED, $urandom_range(0, 16384));
			repeat (30) feed(off_edge());
		end
		feed(15565);

		// clockwise spin
		reg_write(REG_MAX_SPEED, 12345);
		feed(-4916); feed(4916);
		repeat (15) feed(off_centre());
		feed(4915);

		// last follow phase
		reg_write(REG_PROP_GAIN, 256);
		reg_write(REG_INTEG_GAIN, 65535);
		reg_write(REG_DERIV_GAIN, 5120);
		reg_write(REG_MAX_SPEED, 6554);
		reg_write(REG_MIN_SPEED, 0);
		repeat (40) feed(off_edge());
		repeat (2) begin
			reg_write(REG_PROP_GAIN, $urandom_range(0, 65535));
			reg_write(REG_INTEG_GAIN, $urandom_range(0, 300));
			reg_write(REG_DERIV_GAIN, $urandom_range(0, 65535));
			reg_write(REG_MAX_SPEED, $urandom_range(0, 16384));
			reg_write(REG_MIN_SPEED, int'($urandom_range(0, 32768)) - 16384);
			repeat (40) feed(off_edge());
		end
		settle();
		idling = 1'b0;
		repeat (40) feed(off_edge());
		feed(-15565);

		// stopped for good
		repeat (40) feed(any_pos());
		settle();
		repeat (8) @(negedge clk);

		$display("run covered %0d samples, %0d results, %0d register writes", samples_in,
			results_out, reg_writes);
		$display("results per phase 0..6: %0d %0d %0d %0d %0d %0d %0d", seen_phase[0],
			seen_phase[1], seen_phase[2], seen_phase[3], seen_phase[4], seen_phase[5],
			seen_phase[6]);
		if (mismatches == 0 && wheel_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: line_follow_sequence_controller_core.f
rtl/lfsc_pkg.sv
rtl/lfsc_in_if.sv
rtl/lfsc_out_if.sv
rtl/line_follow_sequence_controller_core.sv
rtl/lfsc_checker.sv
tb/tb.sv
